/* src/rfp_pkg.sv */
package rfp_pkg;

	localparam int ITEM_W    = 32;
	localparam int MODE_W    = 2;
	localparam int POS_W     = 4;
	localparam int STAT_W    = 2;
	localparam int CAP_W     = 5;
	localparam int APB_W     = 32;
	localparam int PADDR_W   = 3;
	localparam int DEPTH_DEF = 16;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_PUSH    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_POP     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PEEK    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_PEEK_AT = 2'd3;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
	localparam logic [STAT_W-1:0] ST_POS    = 2'd3;

	// register index, taken from paddr[2]
	localparam logic REG_CAPACITY = 1'b0;

endpackage

/* src/rfp_store.sv */
module rfp_store import rfp_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [IDX_W-1:0]  waddr,
	input  logic [ITEM_W-1:0] wdata,
	input  logic              re,
	input  logic [IDX_W-1:0]  raddr,
	output logic [ITEM_W-1:0] rdata
);

	logic [ITEM_W-1:0] mem [DEPTH];
	logic [ITEM_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port; holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/ring_fifo_with_peek_top.sv */
// Circular FIFO with pop, peek at head and peek at an offset from the head.
// A result passes through s1 and then the output register before it is
// offered, and it transfers once out_stall is low.
// Throughput: one operation per cycle while in_stall is low; pointers and flags
// update at transfer, and the single-port-read slot memory has a registered read.
// Reset (arst_n low, async): queue empty, both indices zero, capacity 16.
// Slot contents are not reset; a capacity write also empties the queue.
module ring_fifo_with_peek_top import rfp_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,

	// operation channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [MODE_W-1:0]  mode,
	input  logic [ITEM_W-1:0]  item_in,
	input  logic [POS_W-1:0]   position,

	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [STAT_W-1:0]  status,
	output logic [ITEM_W-1:0]  item_out,

	// register port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [APB_W-1:0]   pwdata,
	output logic [APB_W-1:0]   prdata,
	output logic               pready
);

	localparam int IDX_W = $clog2(DEPTH);
	// effective capacity reaches DEPTH itself
	localparam int EC_W  = $clog2(DEPTH + 1);
	// room for index + offset and compares against the capacity
	localparam int SUM_W = ((EC_W > POS_W) ? EC_W : POS_W) + 1;

	// ---------------------------------------------------------------
	// Register port. Only capacity lives here; a write to it empties the queue.
	// ---------------------------------------------------------------
	logic             cfg_wr;
	logic [CAP_W-1:0] cap_q;
	logic [EC_W-1:0]  eff_cap;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
	assign prdata = (paddr[2] == REG_CAPACITY) ? {{(APB_W-CAP_W){1'b0}}, cap_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	// zero acts as one, anything above the built depth as the depth
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = EC_W'(1);
		end else if (int'(cap_q) > DEPTH) begin
			eff_cap = EC_W'(DEPTH);
		end else begin
			eff_cap = EC_W'(cap_q);
		end
	end

	// ---------------------------------------------------------------
	// Queue pointers and flags
	// ---------------------------------------------------------------
	logic [IDX_W-1:0] rd_idx_q, wr_idx_q;
	logic             full_q, empty_q;

	function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
			input logic [EC_W-1:0] cap);
		logic [SUM_W-1:0] n;
		n = SUM_W'(idx) + SUM_W'(1);
		return (n >= SUM_W'(cap)) ? '0 : n[IDX_W-1:0];
	endfunction

	// ---------------------------------------------------------------
	// Handshake. s1 holds an issued operation waiting on the memory read;
	// s1 drains only when the output register is empty or its result is taken.
	// ---------------------------------------------------------------
	logic              accept;
	logic              valid_s1, hit_s1;
	logic [STAT_W-1:0] status_s1;
	logic              s1_move;
	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [ITEM_W-1:0] item_q;

	assign s1_move  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_move;
	assign accept   = in_valid && !in_stall;

	// ---------------------------------------------------------------
	// Decode of the offered operation against current pointers
	// ---------------------------------------------------------------
	logic [SUM_W-1:0]  occ_sum, pos_sum;
	logic [EC_W-1:0]   occ;
	logic [IDX_W-1:0]  peek_idx, wr_next, rd_next;
	logic [STAT_W-1:0] status_c;
	logic              push_c, pop_c, read_c;
	logic [IDX_W-1:0]  raddr_c;

	assign wr_next = advance(wr_idx_q, eff_cap);
	assign rd_next = advance(rd_idx_q, eff_cap);

	always_comb begin
		if (full_q) begin
			occ_sum = SUM_W'(eff_cap);
		end else if (empty_q) begin
			occ_sum = '0;
		end else if (wr_idx_q >= rd_idx_q) begin
			occ_sum = SUM_W'(wr_idx_q) - SUM_W'(rd_idx_q);
		end else begin
			occ_sum = SUM_W'(wr_idx_q) + SUM_W'(eff_cap) - SUM_W'(rd_idx_q);
		end
		occ = occ_sum[EC_W-1:0];
	end

	// offset index wraps once at most for offsets below occupancy: head + offset < 2 * capacity
	always_comb begin
		pos_sum = SUM_W'(rd_idx_q) + SUM_W'(position);
		if (pos_sum >= SUM_W'(eff_cap)) begin
			pos_sum = pos_sum - SUM_W'(eff_cap);
		end
		peek_idx = pos_sum[IDX_W-1:0];
	end

	always_comb begin
		status_c = ST_OK;
		push_c   = 1'b0;
		pop_c    = 1'b0;
		read_c   = 1'b0;
		raddr_c  = rd_idx_q;
		unique case (mode)
			MODE_PUSH: begin
				if (full_q) begin
					status_c = ST_FULL;
				end else begin
					push_c = 1'b1;
				end
			end
			MODE_POP: begin
				if (empty_q) begin
					status_c = ST_EMPTY;
				end else begin
					pop_c  = 1'b1;
					read_c = 1'b1;
				end
			end
			MODE_PEEK: begin
				if (empty_q) begin
					status_c = ST_EMPTY;
				end else begin
					read_c = 1'b1;
				end
			end
			MODE_PEEK_AT: begin
				if (empty_q) begin
					status_c = ST_EMPTY;
				end else if (SUM_W'(position) >= SUM_W'(occ)) begin
					status_c = ST_POS;
				end else begin
					read_c  = 1'b1;
					raddr_c = peek_idx;
				end
			end
			default: begin
				status_c = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			wr_idx_q <= '0;
			full_q   <= 1'b0;
			empty_q  <= 1'b1;
		end else if (cfg_wr) begin
			rd_idx_q <= '0;
			wr_idx_q <= '0;
			full_q   <= 1'b0;
			empty_q  <= 1'b1;
		end else if (accept) begin
			if (push_c) begin
				wr_idx_q <= wr_next;
				empty_q  <= 1'b0;
				full_q   <= (wr_next == rd_idx_q);
			end
			if (pop_c) begin
				rd_idx_q <= rd_next;
				full_q   <= 1'b0;
				empty_q  <= (rd_next == wr_idx_q);
			end
		end
	end

	// ---------------------------------------------------------------
	// Slot memory. Each transfer touches at most one slot, and a write
	// lands in memory before any later read samples it, so no forwarding is needed.
	// ---------------------------------------------------------------
	logic [ITEM_W-1:0] rdata;

	rfp_store #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W)
	) u_store (
		.clk   (clk),
		.we    (accept && push_c),
		.waddr (wr_idx_q),
		.wdata (item_in),
		.re    (accept && read_c),
		.raddr (raddr_c),
		.rdata (rdata)
	);

	// ---------------------------------------------------------------
	// s1 and output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_c;
			hit_s1    <= read_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// pushes and rejected operations return a zero item
	always_ff @(posedge clk) begin
		if (s1_move) begin
			status_q <= status_s1;
			item_q   <= hit_s1 ? rdata : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign item_out  = item_q;

`ifndef NO_ASSERTIONS
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(full_q && empty_q))
		else $error("full and empty set together");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(SUM_W'(rd_idx_q) < SUM_W'(eff_cap)) && (SUM_W'(wr_idx_q) < SUM_W'(eff_cap)))
		else $error("queue index beyond capacity");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_move) |=> (valid_s1 && $stable(status_s1)))
		else $error("stalled s1 operation lost");

	a_push_clears_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && push_c && !cfg_wr) |=> !empty_q)
		else $error("queue empty after accepted push");
`endif

endmodule

/* test/ring_fifo_with_peek_checker.sv */
`timescale 1ns / 100ps

module ring_fifo_with_peek_checker import rfp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [MODE_W-1:0]  mode,
	input  logic [ITEM_W-1:0]  item_in,
	input  logic [POS_W-1:0]   position,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [STAT_W-1:0]  status,
	input  logic [ITEM_W-1:0]  item_out,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [APB_W-1:0]   pwdata,
	input  logic               pready,
	output int                 fail_count,
	output int                 outstanding,
	output int                 compared
);

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ITEM_W-1:0] item;
	} reply_t;

	reply_t            owed_replies[$];
	logic [ITEM_W-1:0] slot_mem[DEPTH_DEF];
	int unsigned       rd_ptr;
	int unsigned       wr_ptr;
	bit                is_full;
	bit                is_empty;
	logic [CAP_W-1:0]  cap_reg;

	initial begin
		fail_count  = 0;
		outstanding = 0;
		compared    = 0;
		foreach (slot_mem[i])
			slot_mem[i] = '0;
	end

	// capacity as the queue uses it: 0 acts as 1, above depth acts as depth
	function automatic int unsigned live_cap();
		if (cap_reg == '0)
			return 1;
		if (cap_reg > DEPTH_DEF)
			return DEPTH_DEF;
		return 32'(cap_reg);
	endfunction

	function automatic int unsigned next_slot(input int unsigned idx);
		return (idx + 1 >= live_cap()) ? 0 : idx + 1;
	endfunction

	function automatic int unsigned fill_level();
		if (is_full)
			return live_cap();
		if (is_empty)
			return 0;
		if (wr_ptr >= rd_ptr)
			return wr_ptr - rd_ptr;
		return wr_ptr + live_cap() - rd_ptr;
	endfunction

	function automatic void empty_queue();
		rd_ptr   = 0;
		wr_ptr   = 0;
		is_full  = 1'b0;
		is_empty = 1'b1;
	endfunction

	// one operation against the shadow queue; returns the reply it owes
	function automatic reply_t fifo_answer(input logic [MODE_W-1:0] op,
			input logic [ITEM_W-1:0] data, input logic [POS_W-1:0] pos);
		reply_t      r;
		int unsigned idx;
		r.status = ST_OK;
		r.item   = '0;
		if (op == MODE_PUSH) begin
			if (is_full) begin
				r.status = ST_FULL;
			end else begin
				slot_mem[wr_ptr] = data;
				wr_ptr   = next_slot(wr_ptr);
				is_empty = 1'b0;
				is_full  = (wr_ptr == rd_ptr);
			end
		end else if (is_empty) begin
			r.status = ST_EMPTY;
		end else if (op == MODE_POP) begin
			r.item   = slot_mem[rd_ptr];
			rd_ptr   = next_slot(rd_ptr);
			is_full  = 1'b0;
			is_empty = (rd_ptr == wr_ptr);
		end else if (op == MODE_PEEK) begin
			r.item = slot_mem[rd_ptr];
		end else if (pos >= fill_level()) begin
			r.status = ST_POS;
		end else begin
			idx = rd_ptr + pos;
			if (idx >= live_cap())
				idx -= live_cap();
			r.item = slot_mem[idx];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			cap_reg = CAP_RESET;
			empty_queue();
			owed_replies.delete();
			outstanding = 0;
		end else begin
			// register index sits in paddr[2]; other indices are ignored
			if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
				cap_reg = pwdata[CAP_W-1:0];
				empty_queue();
			end
			if (out_valid && !out_stall) begin
				if (owed_replies.size() == 0) begin
					$error("unexpected result transfer: status %0d item %h",
						status, item_out);
					fail_count++;
				end else begin
					want = owed_replies.pop_front();
					compared++;
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						fail_count++;
					end
					if (item_out !== want.item) begin
						$error("item_out: expected %h, actual %h", want.item, item_out);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				owed_replies.push_back(fifo_answer(mode, item_in, position));
			outstanding = owed_replies.size();
		end
	end

endmodule

/* test/tb_ring_fifo_with_peek_top.sv */
`timescale 1ns / 100ps

module tb_ring_fifo_with_peek_top;
	import rfp_pkg::*;

	// cycles with no transfer of any kind before the run is declared hung;
	// worst natural silence is a long sender gap plus a long receiver stall
	localparam int IDLE_LIMIT = 2000;
	// result passes s1 and the output register after its transfer, leave some margin
	localparam int SETTLE     = 6;
	localparam int PHASES     = 10;
	localparam int PHASE_OPS  = 78;

	localparam logic [PADDR_W-1:0] ADDR_CAPACITY = {REG_CAPACITY, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = 3'd4;

	// burst flavors for the random part
	localparam int FILL  = 0;
	localparam int DRAIN = 1;
	localparam int MIXED = 2;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	logic [MODE_W-1:0]  mode      = MODE_PUSH;
	logic [ITEM_W-1:0]  item_in   = '0;
	logic [POS_W-1:0]   position  = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [STAT_W-1:0]  status;
	logic [ITEM_W-1:0]  item_out;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic [PADDR_W-1:0] paddr     = '0;
	logic [APB_W-1:0]   pwdata    = '0;
	logic [APB_W-1:0]   prdata;
	logic               pready;

	int          fail_count;
	int          outstanding;
	int          compared;
	int          ops_sent   = 0;
	int          reg_writes = 0;
	int          quiet      = 0;
	int          stall_left = 0;
	bit          calm       = 1'b0;   // no gaps or stalls at all while set
	int unsigned cap_eff    = DEPTH_DEF;

	always #10 clk = ~clk;

	ring_fifo_with_peek_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.item_in   (item_in),
		.position  (position),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.item_out  (item_out),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	ring_fifo_with_peek_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.item_in     (item_in),
		.position    (position),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.item_out    (item_out),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.compared    (compared)
	);

	// Gap length: mostly none, some short, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Receiver side: random stalls, changed only at the falling edge.
	always @(negedge clk) begin
		if (calm) begin
			stall_left = 0;
			out_stall  = 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall = 1'b1;
		end else begin
			stall_left = pick_gap();
			out_stall  = (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// Watchdog: any transfer on either channel or a write on the register port
	// counts as progress.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)
				|| (psel && penable && pwrite && pready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= IDLE_LIMIT) begin
			$display("watchdog: %0d cycles without a transfer", IDLE_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// One operation transfer. Valid stays high afterwards so back-to-back
	// transfers need no toggle; a gap drops it first.
	task automatic send_op(input logic [MODE_W-1:0] op, input logic [ITEM_W-1:0] data,
			input logic [POS_W-1:0] pos);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		mode     = op;
		item_in  = data;
		position = pos;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		ops_sent++;
	endtask

	// Block is idle once every owed result is back and the pipe has settled.
	task automatic wait_drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Setup cycle then access cycle; the write lands when pready is seen.
	task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [APB_W-1:0] data);
		wait_drain();
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = addr;
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		reg_writes++;
		if (addr == ADDR_CAPACITY) begin
			if (data[CAP_W-1:0] == '0)
				cap_eff = 1;
			else if (data[CAP_W-1:0] > DEPTH_DEF)
				cap_eff = DEPTH_DEF;
			else
				cap_eff = 32'(data[CAP_W-1:0]);
		end
	endtask

	// Operation mix per burst flavor: fill leans on push, drain on pop.
	function automatic logic [MODE_W-1:0] pick_mode(input int flavor);
		int r;
		r = $urandom_range(0, 99);
		case (flavor)
			FILL: begin
				if (r < 60) return MODE_PUSH;
				if (r < 70) return MODE_POP;
				if (r < 85) return MODE_PEEK;
				return MODE_PEEK_AT;
			end
			DRAIN: begin
				if (r < 10) return MODE_PUSH;
				if (r < 65) return MODE_POP;
				if (r < 80) return MODE_PEEK;
				return MODE_PEEK_AT;
			end
			default: begin
				if (r < 30) return MODE_PUSH;
				if (r < 55) return MODE_POP;
				if (r < 70) return MODE_PEEK;
				return MODE_PEEK_AT;
			end
		endcase
	endfunction

	// Mostly offsets within the current capacity, sometimes any 4-bit value.
	function automatic logic [POS_W-1:0] pick_pos();
		if ($urandom_range(0, 3) == 0)
			return POS_W'($urandom_range(0, 15));
		return POS_W'($urandom_range(0, cap_eff - 1));
	endfunction

	initial begin
		logic [CAP_W-1:0] cap_plan[PHASES];
		logic [APB_W-1:0] wdata;
		int               done;
		int               burst;
		int               flavor;

		cap_plan = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd2, 5'd17, 5'd3, 5'd8, 5'd15, 5'd5};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// --- directed: reset capacity of 16 ---
		// every read-type op on an empty queue is rejected as empty
		send_op(MODE_POP,     '0, '0);
		send_op(MODE_PEEK,    '0, '0);
		send_op(MODE_PEEK_AT, '0, '0);
		send_op(MODE_PUSH,    32'h0000_0000, 4'hF);
		send_op(MODE_PUSH,    32'hFFFF_FFFF, 4'h0);
		send_op(MODE_PEEK,    '0, '0);
		send_op(MODE_PEEK_AT, '0, 4'd1);
		// offset equal to occupancy, and the largest offset: both out of range
		send_op(MODE_PEEK_AT, '0, 4'd2);
		send_op(MODE_PEEK_AT, '0, 4'd15);
		send_op(MODE_POP,     '0, '0);

		// write to an unmapped register must leave the queue alone
		reg_write(ADDR_UNMAPPED, 32'h0000_0005);
		send_op(MODE_PEEK,    32'h1234_5678, '0);

		// capacity 0 behaves as a single slot
		reg_write(ADDR_CAPACITY, 32'h0000_0000);
		send_op(MODE_PUSH,    32'hA5A5_A5A5, '0);
		send_op(MODE_PUSH,    32'h5A5A_5A5A, '0);
		send_op(MODE_PEEK_AT, '0, '0);
		send_op(MODE_POP,     '0, '0);
		send_op(MODE_POP,     '0, '0);

		// capacity 2: fill, reject when full, wrap the indices
		reg_write(ADDR_CAPACITY, 32'h0000_0002);
		send_op(MODE_PUSH,    32'h0000_0001, '0);
		send_op(MODE_PUSH,    32'h8000_0000, '0);
		send_op(MODE_PUSH,    32'hDEAD_BEEF, '0);
		send_op(MODE_PEEK_AT, '0, 4'd1);
		send_op(MODE_POP,     '0, '0);
		send_op(MODE_PUSH,    32'h7FFF_FFFF, '0);
		send_op(MODE_PEEK_AT, '0, 4'd1);

		// --- random: one capacity per phase, fill/drain/mixed bursts ---
		for (int ph = 0; ph < PHASES; ph++) begin
			// upper data bits are junk the register should drop
			wdata = $urandom();
			wdata[CAP_W-1:0] = (ph >= 6 && $urandom_range(0, 1) == 1)
				? 5'($urandom_range(1, DEPTH_DEF)) : cap_plan[ph];
			reg_write(ADDR_CAPACITY, wdata);
			calm = ($urandom_range(0, 3) == 0);
			done = 0;
			while (done < PHASE_OPS) begin
				flavor = $urandom_range(FILL, MIXED);
				burst  = $urandom_range(1, 2 * cap_eff + 2);
				for (int k = 0; k < burst && done < PHASE_OPS; k++) begin
					send_op(pick_mode(flavor), $urandom(), pick_pos());
					done++;
				end
			end
			calm = 1'b0;
		end

		wait_drain();

		$display("Sent %0d operations through %0d register writes (capacities 0..31).",
			ops_sent, reg_writes);
		$display("Compared %0d results; %0d mismatches.", compared, fail_count);
		if (fail_count == 0 && outstanding == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

/* filelist.f */
src/rfp_pkg.sv
src/rfp_store.sv
src/ring_fifo_with_peek_top.sv
test/ring_fifo_with_peek_checker.sv
test/tb_ring_fifo_with_peek_top.sv
